FILE: src/rps_pkg.sv
`default_nettype none
package rps_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_PRIMARY_BASE = 2'd0,
		REG_MIRROR_DELTA = 2'd1,
		REG_IMAGE_SIZE   = 2'd2
	} cfg_reg_t;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned CNT_W     = 3;
	localparam int unsigned REL_W     = 31;

	// result kinds
	localparam logic KIND_RELOC   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// summary status codes
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_NO_RELOC = 1'b1;

	localparam logic [CNT_W-1:0] FULL_WORD_BYTES = 3'd4;
	localparam logic [REL_W-1:0] REL_MAX = {REL_W{1'b1}};

	// result buffer in the back end, takes two entries per request at most
	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	// input request
	typedef struct packed {
		logic [WORD_W-1:0] primary_word;
		logic [WORD_W-1:0] mirror_word;
		logic [CNT_W-1:0]  byte_count;
		logic              last_item;
	} scan_req_t;

	// result item
	typedef struct packed {
		logic              kind;
		logic [WORD_W-1:0] word_offset;
		logic [WORD_W-1:0] target_offset;
		logic [REL_W-1:0]  relocation_total;
		logic [WORD_W-1:0] residual_bytes;
		logic              status;
		logic              last_result;
	} scan_rsp_t;

	// classified request passed from front to back
	typedef struct packed {
		logic              reloc;
		logic              last;
		logic [WORD_W-1:0] word_offset;
		logic [WORD_W-1:0] target_offset;
		logic [CNT_W-1:0]  diff_bytes;
	} scan_rec_t;

endpackage
`default_nettype wire

FILE: src/rps_front.sv
`default_nettype none
module rps_front (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	input  wire  [rps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [rps_pkg::WORD_W-1:0]    cfg_data,
	input  wire                           take,
	input  wire  rps_pkg::scan_req_t      req,
	output rps_pkg::scan_rec_t            rec
);
	import rps_pkg::*;

	logic [WORD_W-1:0] primary_base_q;
	logic [WORD_W-1:0] mirror_delta_q;
	logic [WORD_W-1:0] image_size_q;
	logic [WORD_W-1:0] pos_q;

	logic [CNT_W-1:0]  cnt;
	logic [WORD_W:0]   end_addr;
	logic [WORD_W:0]   expect_val;
	logic              reloc;
	logic [CNT_W-1:0]  diff;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primary_base_q <= '0;
			mirror_delta_q <= '0;
			image_size_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PRIMARY_BASE: primary_base_q <= cfg_data;
				REG_MIRROR_DELTA: mirror_delta_q <= cfg_data;
				REG_IMAGE_SIZE:   image_size_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	// clamp byte count to a full word
	always_comb begin
		cnt = (req.byte_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : req.byte_count;
	end

	// relocation test: range check and mirror match without wrap
	always_comb begin
		end_addr   = {1'b0, primary_base_q} + {1'b0, image_size_q};
		expect_val = {1'b0, req.primary_word} + {1'b0, mirror_delta_q};
		reloc = (cnt == FULL_WORD_BYTES)
			&& (req.primary_word >= primary_base_q)
			&& ({1'b0, req.primary_word} <= end_addr)
			&& !expect_val[WORD_W]
			&& (req.mirror_word == expect_val[WORD_W-1:0]);
	end

	// differing valid bytes
	always_comb begin
		diff = '0;
		for (int i = 0; i < 4; i++) begin
			if ((CNT_W'(i) < cnt)
				&& (req.primary_word[8*i +: 8] != req.mirror_word[8*i +: 8])) begin
				diff = diff + CNT_W'(1);
			end
		end
	end

	// classified record
	always_comb begin
		rec.reloc         = reloc;
		rec.last          = req.last_item;
		rec.word_offset   = pos_q;
		rec.target_offset = req.primary_word - primary_base_q;
		rec.diff_bytes    = reloc ? '0 : diff;
	end

	// byte position, restarts after the last request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			pos_q <= req.last_item ? '0 : pos_q + WORD_W'(cnt);
		end
	end

endmodule
`default_nettype wire

FILE: src/rps_queue.sv
`default_nettype none
module rps_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_en,
	input  wire  rps_pkg::scan_rec_t wr_data,
	output logic                full,
	input  wire                 rd_en,
	output rps_pkg::scan_rec_t  rd_data,
	output logic                empty
);
	import rps_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

	scan_rec_t         mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == CNT_QW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_QW'(do_wr) - CNT_QW'(do_rd);
		end
	end

endmodule
`default_nettype wire

FILE: src/rps_back.sv
`default_nettype none
module rps_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 rec_avail,
	input  wire  rps_pkg::scan_rec_t rec,
	output logic                rec_take,
	output logic                empty,
	input  wire                 pop,
	output rps_pkg::scan_rsp_t  rsp
);
	import rps_pkg::*;

	scan_rsp_t            out_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] count_q;

	logic [REL_W-1:0]     rel_q;
	logic [WORD_W-1:0]    res_q;
	logic [REL_W-1:0]     rel_new;
	logic [WORD_W:0]      res_sum;
	logic [WORD_W-1:0]    res_new;

	logic                 do_pop;
	logic [OUT_CNT_W:0]   free;
	logic [1:0]           n_wr;
	scan_rsp_t            reloc_rsp;
	scan_rsp_t            sum_rsp;
	scan_rsp_t            first_rsp;

	assign empty  = (count_q == '0);
	assign do_pop = pop && !empty;
	assign rsp    = out_q[rd_ptr_q];

	// take a record when two result slots are free
	always_comb begin
		free     = (OUT_CNT_W + 1)'(OUT_DEPTH) - {1'b0, count_q} + (OUT_CNT_W + 1)'(do_pop);
		rec_take = rec_avail && (free >= (OUT_CNT_W + 1)'(2));
		n_wr     = 2'(rec.reloc) + 2'(rec.last);
	end

	// saturating counter updates
	always_comb begin
		rel_new = (rec.reloc && (rel_q != REL_MAX)) ? rel_q + REL_W'(1) : rel_q;
		res_sum = {1'b0, res_q} + (WORD_W + 1)'(rec.diff_bytes);
		res_new = res_sum[WORD_W] ? {WORD_W{1'b1}} : res_sum[WORD_W-1:0];
	end

	// result records
	always_comb begin
		reloc_rsp                  = '0;
		reloc_rsp.kind             = KIND_RELOC;
		reloc_rsp.word_offset      = rec.word_offset;
		reloc_rsp.target_offset    = rec.target_offset;

		sum_rsp                    = '0;
		sum_rsp.kind               = KIND_SUMMARY;
		sum_rsp.relocation_total   = rel_new;
		sum_rsp.residual_bytes     = res_new;
		sum_rsp.status             = (rel_new == '0) ? STATUS_NO_RELOC : STATUS_OK;
		sum_rsp.last_result        = 1'b1;

		first_rsp = rec.reloc ? reloc_rsp : sum_rsp;
	end

	// result storage, relocation entry ahead of the summary
	always_ff @(posedge clk) begin
		if (rec_take) begin
			if (n_wr != 2'd0) begin
				out_q[wr_ptr_q] <= first_rsp;
			end
			if (n_wr == 2'd2) begin
				out_q[wr_ptr_q + OUT_PTR_W'(1)] <= sum_rsp;
			end
		end
	end

	// buffer pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (rec_take) begin
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(n_wr);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			count_q <= count_q + (rec_take ? OUT_CNT_W'(n_wr) : '0) - OUT_CNT_W'(do_pop);
		end
	end

	// run counters, cleared after the summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q <= '0;
			res_q <= '0;
		end else if (rec_take) begin
			rel_q <= rec.last ? '0 : rel_new;
			res_q <= rec.last ? '0 : res_new;
		end
	end

endmodule
`default_nettype wire

FILE: src/relocation_pair_scanner_unit.sv
`default_nettype none
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+----------------------------
// request   | in        | push, full                 | req (scan_req_t)
// result    | out       | empty, pop                 | rsp (scan_rsp_t)
// config    | in        | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// one request per cycle while full is low; the front classifies it in the cycle it is pushed
// results pass from the request queue through the back end into the result buffer
// before they reach the result ports; a request that ends in both a relocation entry
// and the summary writes both results in the same cycle
// the result buffer fills and stops the back end when pop stays low, the
// request queue then fills and raises full
// reset clears queues, position and counters; configuration reads as zero
module relocation_pair_scanner_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           push,
	output logic                          full,
	input  wire  rps_pkg::scan_req_t      req,
	output logic                          empty,
	input  wire                           pop,
	output rps_pkg::scan_rsp_t            rsp,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [rps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [rps_pkg::WORD_W-1:0]    cfg_data
);
	import rps_pkg::*;

	scan_rec_t front_rec;
	scan_rec_t back_rec;
	logic      take;
	logic      q_empty;
	logic      rec_take;

	assign cfg_ready = 1'b1;
	assign take      = push && !full;

	// classify requests
	rps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.req       (req),
		.rec       (front_rec)
	);

	// decoupling queue
	rps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_rec),
		.full    (full),
		.rd_en   (rec_take),
		.rd_data (back_rec),
		.empty   (q_empty)
	);

	// count and emit results
	rps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_avail (!q_empty),
		.rec       (back_rec),
		.rec_take  (rec_take),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
